@@ rtl/hex_grid_diffusion_stencil_assert.svh @@
// ----------------------------------------------------------------------------
// Hex grid diffusion stencil - assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEX_GRID_DIFFUSION_STENCIL_ASSERT_SVH
`define HEX_GRID_DIFFUSION_STENCIL_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HGDS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hex grid stencil check failed");

// next-cycle implication
`define HGDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hex grid stencil check failed");

`else

`define HGDS_ASSERT_IMPL(label, ante, cons)
`define HGDS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/hgds_pkg.sv @@
// ----------------------------------------------------------------------------
// Hex grid diffusion stencil - package
// Register codes, fixed widths and shared types.
// ----------------------------------------------------------------------------
package hgds_pkg;

  localparam int CFG_DATA_W      = 16;
  localparam int HEIGHT_REG_W    = 11;
  localparam int WIDTH_REG_W     = 16;
  localparam int EMIT_W          = 26;
  localparam int GRID_HEIGHT_RST = 64;
  localparam int GRID_WIDTH_RST  = 64;
  localparam int GRID_MIN        = 3;

  // (6*c + six neighbors) / 12, half away from zero
  localparam int ROUND_BIAS      = 6;

  localparam int OUTQ_DEPTH      = 8;
  localparam int OUTQ_PTR_W      = 3;
  localparam int OUTQ_CNT_W      = 4;

  typedef enum logic [0:0] {
    REG_GRID_HEIGHT = 1'b0,
    REG_GRID_WIDTH  = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_SAMPLE = 1'b0,
    KIND_FLUSH  = 1'b1
  } item_kind_t;

  // result control carried down the pipeline
  typedef struct packed {
    logic valid;
    logic interior;
    logic odd;
    logic last;
  } res_ctl_t;

endpackage

@@ rtl/hex_grid_diffusion_stencil.sv @@
// ----------------------------------------------------------------------------
// Hex grid diffusion stencil
// Streaming hexagonal Laplacian smoothing over a column-major sample grid.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the credit limit below allows. Samples
// arrive column by column; a single line store (one read and one write
// port, entry = the two previous columns at one row) feeds a 3x3 register
// window, and each interior point gives (6*c + six hex neighbors)/12 rounded
// half away from zero, border points give zero. The item that causes a result
// is one column plus one sample after the matching grid point. After the last
// sample of a frame, one flush item drains each pending result. An 8-entry
// output queue with credit tracking decouples the output: input is taken as
// long as fewer than 8 results are accepted but not yet transferred. A register
// write restarts the frame; make it only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------

`include "hex_grid_diffusion_stencil_assert.svh"

module hex_grid_diffusion_stencil #(
  parameter int MAX_HEIGHT  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,   // sample
  input  logic                                  in_tuser,   // kind

  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,  // smoothed
  output logic                                  out_tlast,  // last_of_grid

  input  logic                                  cfg_we,
  input  hgds_pkg::cfg_reg_t                    cfg_addr,
  input  logic [hgds_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  import hgds_pkg::*;

  localparam int TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
  localparam int TOT_W    = HGT_W + WIDTH_REG_W;
  localparam int CMP_W    = (TOT_W > EMIT_W) ? TOT_W : EMIT_W;
  localparam int HGT_RST  = (GRID_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : GRID_HEIGHT_RST;
  localparam int LAST_RST = HGT_RST * GRID_WIDTH_RST - 1;

  // divide-by-12 datapath: t = (|S| + 6) >> 2, then t/3 split at an even
  // bit H so that t/3 = th*(2^H-1)/3 + (th + tl)/3
  localparam int SUM_W  = SAMPLE_BITS + 4;
  localparam int T_W    = SUM_W - 2;
  localparam int H      = 2 * ((T_W + 2) / 4);
  localparam int TH_W   = T_W - H;
  localparam int U_W    = ((TH_W > H) ? TH_W : H) + 1;
  localparam int N      = U_W + 2;
  localparam int RW     = U_W + N;
  localparam int MUL_HI = ((1 << H) - 1) / 3;
  localparam int RECIP  = (1 << N) / 3 + 1;

  // --------------------------------------------------------------------------
  // Configuration and frame position
  // --------------------------------------------------------------------------
  logic [HGT_W-1:0]        h_eff_r;
  logic [WIDTH_REG_W-1:0]  w_eff_r;
  logic [CMP_W-1:0]        last_idx_r;
  logic [ROW_W-1:0]        row_r;
  logic [WIDTH_REG_W-1:0]  col_r;
  logic [CMP_W-1:0]        emit_r;

  logic [HEIGHT_REG_W-1:0] cfg_h_val;
  logic [HGT_W-1:0]        cfg_h_clamp;
  logic [WIDTH_REG_W-1:0]  cfg_w_clamp;
  logic [HGT_W-1:0]        cfg_h_sel;
  logic [WIDTH_REG_W-1:0]  cfg_w_sel;
  logic [TOT_W-1:0]        cfg_total;
  logic [CMP_W-1:0]        last_idx_nxt;

  always_comb begin
    cfg_h_val = cfg_wdata[HEIGHT_REG_W-1:0];
    if (cfg_h_val < HEIGHT_REG_W'(GRID_MIN)) begin
      cfg_h_clamp = HGT_W'(GRID_MIN);
    end else if (32'(cfg_h_val) > MAX_HEIGHT) begin
      cfg_h_clamp = HGT_W'(MAX_HEIGHT);
    end else begin
      cfg_h_clamp = HGT_W'(cfg_h_val);
    end
    cfg_w_clamp  = (cfg_wdata < CFG_DATA_W'(GRID_MIN)) ? WIDTH_REG_W'(GRID_MIN)
                                                       : WIDTH_REG_W'(cfg_wdata);
    cfg_h_sel    = (cfg_addr == REG_GRID_HEIGHT) ? cfg_h_clamp : h_eff_r;
    cfg_w_sel    = (cfg_addr == REG_GRID_WIDTH)  ? cfg_w_clamp : w_eff_r;
    cfg_total    = TOT_W'(cfg_h_sel) * TOT_W'(cfg_w_sel);
    last_idx_nxt = CMP_W'(cfg_total) - CMP_W'(1);
  end

  // --------------------------------------------------------------------------
  // Input side: position bookkeeping and result classification
  // --------------------------------------------------------------------------
  logic [OUTQ_CNT_W-1:0] pend_r;
  logic                  in_fire;
  logic                  is_flush;
  logic                  restart;
  logic [WIDTH_REG_W-1:0] x;
  logic [ROW_W-1:0]      y;
  logic [CMP_W-1:0]      e;
  logic [CMP_W-1:0]      emit_inc;
  logic [CMP_W-1:0]      emit_wrap;
  logic [ROW_W:0]        row_inc;
  logic                  row_wrap;
  logic                  produce;
  res_ctl_t              ctl_in;

  assign in_tready = rst_n && (pend_r < OUTQ_CNT_W'(OUTQ_DEPTH));
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    is_flush  = (item_kind_t'(in_tuser) == KIND_FLUSH);
    // a sample after a complete frame opens the next one
    restart   = !is_flush && (col_r >= w_eff_r);
    x         = restart ? '0 : col_r;
    y         = restart ? '0 : row_r;
    e         = restart ? '0 : emit_r;
    emit_inc  = e + CMP_W'(1);
    emit_wrap = CMP_W'(emit_inc[EMIT_W-1:0]);
    row_inc   = {1'b0, y} + (ROW_W + 1)'(1);
    row_wrap  = (HGT_W + 1)'(row_inc) >= (HGT_W + 1)'(h_eff_r);
    if (is_flush) begin
      produce = (col_r >= w_eff_r) && (emit_r <= last_idx_r);
    end else begin
      produce = (x >= WIDTH_REG_W'(2)) || ((x == WIDTH_REG_W'(1)) && (y != '0));
    end
    ctl_in.valid    = in_fire && produce;
    ctl_in.interior = !is_flush && (x >= WIDTH_REG_W'(2)) && (y >= ROW_W'(2));
    ctl_in.odd      = !x[0];             // center column is x-1
    ctl_in.last     = (e == last_idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_eff_r    <= HGT_W'(HGT_RST);
      w_eff_r    <= WIDTH_REG_W'(GRID_WIDTH_RST);
      last_idx_r <= CMP_W'(LAST_RST);
      row_r      <= '0;
      col_r      <= '0;
      emit_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRID_HEIGHT: h_eff_r <= cfg_h_clamp;
        REG_GRID_WIDTH:  w_eff_r <= cfg_w_clamp;
      endcase
      last_idx_r <= last_idx_nxt;
      row_r      <= '0;
      col_r      <= '0;
      emit_r     <= '0;
    end else if (in_fire) begin
      if (is_flush) begin
        if (produce) begin
          emit_r <= emit_inc;
        end
      end else begin
        emit_r <= produce ? emit_wrap : e;
        if (row_wrap) begin
          row_r <= '0;
          col_r <= x + WIDTH_REG_W'(1);
        end else begin
          row_r <= row_inc[ROW_W-1:0];
          col_r <= x;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store read data; write back and window shift
  // --------------------------------------------------------------------------
  logic [2*SAMPLE_BITS-1:0] line_mem [MAX_HEIGHT];
  logic [2*SAMPLE_BITS-1:0] rd_data_r;
  logic                     p1_shift_r;
  logic [ROW_W-1:0]         p1_addr_r;
  logic [SAMPLE_BITS-1:0]   p1_sample_r;
  res_ctl_t                 p1_ctl_r;
  logic signed [SAMPLE_BITS-1:0] win_r [3][3];   // [column x-2..x][row y-2..y]

  // entry: upper half = column x-2, lower half = column x-1
  always_ff @(posedge clk) begin
    if (in_fire && !is_flush) begin
      rd_data_r   <= line_mem[y];
      p1_addr_r   <= y;
      p1_sample_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (p1_shift_r) begin
      line_mem[p1_addr_r] <= {rd_data_r[SAMPLE_BITS-1:0], p1_sample_r};
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= rd_data_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
      win_r[1][2] <= rd_data_r[SAMPLE_BITS-1:0];
      win_r[2][2] <= p1_sample_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..4: stencil sum, divide by 12
  // --------------------------------------------------------------------------
  res_ctl_t                 p2_ctl_r;
  res_ctl_t                 p3_ctl_r;
  res_ctl_t                 p4_ctl_r;
  logic signed [SUM_W-1:0]  wv [3][3];
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  sum_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wv[i][j] = SUM_W'(win_r[i][j]);
      end
    end
    sum_nxt = (wv[1][1] <<< 2) + (wv[1][1] <<< 1)
            + wv[1][0] + wv[1][2] + wv[0][1] + wv[2][1]
            + (p2_ctl_r.odd ? (wv[0][0] + wv[2][0]) : (wv[0][2] + wv[2][2]));
  end

  logic             neg_nxt;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] biased;
  logic [T_W-1:0]   t_q;
  logic [TH_W-1:0]  t_hi;
  logic [H-1:0]     t_lo;
  logic [U_W-1:0]   u_nxt;
  logic [T_W-1:0]   prod_hi_nxt;
  logic             neg_r;
  logic [U_W-1:0]   u_r;
  logic [T_W-1:0]   prod_hi_r;

  always_comb begin
    neg_nxt     = sum_r[SUM_W-1];
    mag         = neg_nxt ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    biased      = mag + SUM_W'(ROUND_BIAS);
    t_q         = biased[SUM_W-1:2];
    t_hi        = t_q[T_W-1:H];
    t_lo        = t_q[H-1:0];
    u_nxt       = U_W'(t_hi) + U_W'(t_lo);
    prod_hi_nxt = T_W'(t_hi) * T_W'(MUL_HI);
  end

  // --------------------------------------------------------------------------
  // Stage 5: finish quotient, sign, saturate; write output queue
  // --------------------------------------------------------------------------
  logic [RW-1:0]          lo_prod;
  logic [T_W-1:0]         q_mag;
  logic [SAMPLE_BITS-1:0] q_trunc;
  logic [SAMPLE_BITS-1:0] res_val;

  always_comb begin
    lo_prod = RW'(u_r) * RW'(RECIP);
    q_mag   = prod_hi_r + T_W'(lo_prod[RW-1:N]);
    q_trunc = q_mag[SAMPLE_BITS-1:0];
    if (!p4_ctl_r.interior) begin
      res_val = '0;
    end else if (neg_r) begin
      res_val = (q_mag > T_W'(1) << (SAMPLE_BITS - 1))
              ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}} : SAMPLE_BITS'(-q_trunc);
    end else begin
      res_val = (q_mag > (T_W'(1) << (SAMPLE_BITS - 1)) - T_W'(1))
              ? {1'b0, {(SAMPLE_BITS - 1){1'b1}}} : q_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_shift_r <= 1'b0;
      p1_ctl_r   <= '0;
      p2_ctl_r   <= '0;
      p3_ctl_r   <= '0;
      p4_ctl_r   <= '0;
    end else begin
      p1_shift_r <= in_fire && !is_flush;
      p1_ctl_r   <= ctl_in;
      p2_ctl_r   <= p1_ctl_r;
      p3_ctl_r   <= p2_ctl_r;
      p4_ctl_r   <= p3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    neg_r     <= neg_nxt;
    u_r       <= u_nxt;
    prod_hi_r <= prod_hi_nxt;
  end

  // --------------------------------------------------------------------------
  // Output queue and credit count
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] oq_val_r  [OUTQ_DEPTH];
  logic                   oq_last_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]  oq_wr_r;
  logic [OUTQ_PTR_W-1:0]  oq_rd_r;
  logic [OUTQ_CNT_W-1:0]  oq_cnt_r;
  logic                   out_fire;
  logic                   oq_push;

  assign out_fire   = out_tvalid && out_tready;
  assign oq_push    = p4_ctl_r.valid;
  assign out_tvalid = (oq_cnt_r != '0);
  assign out_tdata  = TDATA_W'(oq_val_r[oq_rd_r]);
  assign out_tlast  = oq_last_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_val_r[oq_wr_r]  <= res_val;
      oq_last_r[oq_wr_r] <= p4_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
      pend_r   <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + OUTQ_PTR_W'(1);
      end
      if (out_fire) begin
        oq_rd_r <= oq_rd_r + OUTQ_PTR_W'(1);
      end
      oq_cnt_r <= oq_cnt_r + OUTQ_CNT_W'(oq_push) - OUTQ_CNT_W'(out_fire);
      pend_r   <= pend_r + OUTQ_CNT_W'(ctl_in.valid) - OUTQ_CNT_W'(out_fire);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `HGDS_ASSERT_IMPL(a_credit_cover, 1'b1, oq_cnt_r <= pend_r && pend_r <= OUTQ_CNT_W'(OUTQ_DEPTH))
  `HGDS_ASSERT_IMPL(a_line_rw_apart, p1_shift_r && in_fire && !is_flush && !$past(cfg_we), p1_addr_r != y)
  `HGDS_ASSERT_NEXT(a_cfg_restart, cfg_we, row_r == '0 && col_r == '0 && emit_r == '0)

endmodule
